FILE: sv/bracket_quote_balance_checker_unit_assert.svh
// assertion macros for the bracket and quote balance checker
// used by bracket_quote_balance_checker_unit, expects clk and rst_n in scope
`ifndef BRACKET_QUOTE_BALANCE_CHECKER_UNIT_ASSERT_SVH
`define BRACKET_QUOTE_BALANCE_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication
`define BQC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BQC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bqc_pkg.sv
// constants and types for the bracket and quote balance checker
// no dependencies
package bqc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int LINE_BITS   = 20;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam logic [LINE_BITS-1:0] LINE_MAX   = {LINE_BITS{1'b1}};
    localparam logic [LINE_BITS-1:0] LINE_FIRST = LINE_BITS'(1);

    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_NL      = 8'h0A;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_ODD_QUOTE   = 3'd1,
        ST_UNEXP_CLOSE = 3'd2,
        ST_UNCLOSED    = 3'd3,
        ST_OVERFLOW    = 3'd4
    } status_t;

    typedef struct packed {
        logic [LINE_BITS-1:0] line;
        logic                 square;
    } entry_t;

    typedef struct packed {
        status_t              status;
        logic [LINE_BITS-1:0] line;
        logic [7:0]           ch;
    } result_t;

endpackage

FILE: sv/bqc_text_if.sv
// text channel: one byte of the text per beat
// depends on no other file
interface bqc_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

FILE: sv/bqc_report_if.sv
// report channel: one check result per beat
// depends on bqc_pkg
interface bqc_report_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [bqc_pkg::LINE_BITS-1:0] error_line;
    logic [7:0]                    error_char;

    modport source (output valid, output status, output error_line, output error_char,
                    input ready);
    modport sink (input valid, input status, input error_line, input error_char,
                  output ready);
endinterface

FILE: sv/bracket_quote_balance_checker_unit.sv
// bracket and quote balance checker, top level
// depends on bqc_pkg, bqc_text_if, bqc_report_if and the assertion macro header
//
//   channel  role  payload                              beat
//   text     sink  char_code, last_char                 one byte
//   report   src   status, error_line, error_char       one result per last byte
//
// one byte is taken every cycle while skid is free; the stack top and the entry below
// it sit in registers, the entry below is refetched from the stack ram each cycle
// the result of a last byte is registered in the report register, or in skid if busy
// reset clears all control state; the stack ram is never cleared
// two results can wait on report; text.ready falls only when both are held
`include "bracket_quote_balance_checker_unit_assert.svh"

module bracket_quote_balance_checker_unit
(
    input  logic                clk,
    input  logic                rst_n,
    bqc_text_if.sink            text,
    bqc_report_if.source        report
);

    logic [bqc_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [bqc_pkg::LINE_BITS-1:0] line_reg, line_next;
    logic                          parity_reg, parity_next;
    logic                          prev_bs_reg, prev_bs_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [7:0]                    pend_char_reg, pend_char_next;
    logic                          err_valid_reg, err_valid_next;
    bqc_pkg::status_t              err_status_reg, err_status_next;
    logic [bqc_pkg::LINE_BITS-1:0] err_line_reg, err_line_next;
    logic [7:0]                    err_char_reg, err_char_next;
    bqc_pkg::entry_t               top_reg, top_next;
    bqc_pkg::entry_t               below_reg;
    bqc_pkg::entry_t               push_entry;
    bqc_pkg::entry_t               mem [bqc_pkg::STACK_DEPTH];

    logic                          out_valid_reg, out_valid_next;
    bqc_pkg::result_t              out_data_reg, out_data_next;
    logic                          skid_valid_reg, skid_valid_next;
    bqc_pkg::result_t              skid_data_reg, skid_data_next;

    logic                          fire;
    logic                          res_new;
    logic                          out_fire;
    logic                          push;
    logic                          pop;
    logic                          is_open;
    logic                          is_close;
    logic                          match_ok;
    logic [7:0]                    c;
    logic [bqc_pkg::CNT_W-1:0]     rd_sum;
    logic [bqc_pkg::ADDR_W-1:0]    rd_addr;
    bqc_pkg::result_t              res;

    assign c        = text.char_code;
    assign fire     = text.valid && text.ready;
    assign res_new  = fire && text.last_char;
    assign out_fire = out_valid_reg && report.ready;
    assign is_open  = (c == bqc_pkg::CH_LCURLY) || (c == bqc_pkg::CH_LSQUARE);
    assign is_close = (c == bqc_pkg::CH_RCURLY) || (c == bqc_pkg::CH_RSQUARE);
    assign match_ok = (count_reg != '0)
                   && ((c == bqc_pkg::CH_RSQUARE) ? top_reg.square : !top_reg.square);

    assign push_entry.line   = line_reg;
    assign push_entry.square = (c == bqc_pkg::CH_LSQUARE);

    assign text.ready        = !skid_valid_reg;
    assign report.valid      = out_valid_reg;
    assign report.status     = out_data_reg.status;
    assign report.error_line = out_data_reg.line;
    assign report.error_char = out_data_reg.ch;

    // per-byte update
    always_comb
    begin
        count_next      = count_reg;
        line_next       = line_reg;
        parity_next     = parity_reg;
        prev_bs_next    = prev_bs_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        err_valid_next  = err_valid_reg;
        err_status_next = err_status_reg;
        err_line_next   = err_line_reg;
        err_char_next   = err_char_reg;
        top_next        = top_reg;
        push            = 1'b0;
        pop             = 1'b0;

        if (fire)
        begin
            prev_bs_next = (c == bqc_pkg::CH_BSLASH);
            if (!err_valid_reg)
            begin
                if (c == bqc_pkg::CH_NL)
                begin
                    if (parity_reg)
                    begin
                        err_valid_next  = 1'b1;
                        err_status_next = bqc_pkg::ST_ODD_QUOTE;
                        err_line_next   = line_reg;
                        err_char_next   = bqc_pkg::CH_QUOTE;
                    end
                    else if (pend_valid_reg)
                    begin
                        err_valid_next  = 1'b1;
                        err_status_next = ((pend_char_reg == bqc_pkg::CH_LCURLY)
                                        || (pend_char_reg == bqc_pkg::CH_LSQUARE))
                                        ? bqc_pkg::ST_OVERFLOW : bqc_pkg::ST_UNEXP_CLOSE;
                        err_line_next   = line_reg;
                        err_char_next   = pend_char_reg;
                    end
                    parity_next     = 1'b0;
                    pend_valid_next = 1'b0;
                    pend_char_next  = '0;
                    if (line_reg != bqc_pkg::LINE_MAX)
                    begin
                        line_next = line_reg + 1'b1;
                    end
                end
                else
                begin
                    if ((c == bqc_pkg::CH_QUOTE) && !prev_bs_reg)
                    begin
                        parity_next = !parity_reg;
                    end
                    if (!pend_valid_reg)
                    begin
                        if (is_open)
                        begin
                            if (count_reg >= bqc_pkg::CNT_W'(bqc_pkg::STACK_DEPTH))
                            begin
                                pend_valid_next = 1'b1;
                                pend_char_next  = c;
                            end
                            else
                            begin
                                push = 1'b1;
                            end
                        end
                        else if (is_close)
                        begin
                            if (match_ok)
                            begin
                                pop = 1'b1;
                            end
                            else
                            begin
                                pend_valid_next = 1'b1;
                                pend_char_next  = c;
                            end
                        end
                    end
                end
            end
            if (push)
            begin
                count_next = count_reg + 1'b1;
                top_next   = push_entry;
            end
            else if (pop)
            begin
                count_next = count_reg - 1'b1;
                top_next   = below_reg;
            end
        end
    end

    // end-of-text check on the updated state
    always_comb
    begin
        res = '{status: bqc_pkg::ST_OK, line: '0, ch: '0};
        if (err_valid_next)
        begin
            res = '{status: err_status_next, line: err_line_next, ch: err_char_next};
        end
        else if (parity_next)
        begin
            res = '{status: bqc_pkg::ST_ODD_QUOTE, line: line_next, ch: bqc_pkg::CH_QUOTE};
        end
        else if (pend_valid_next)
        begin
            res.line = line_next;
            res.ch   = pend_char_next;
            res.status = ((pend_char_next == bqc_pkg::CH_LCURLY)
                       || (pend_char_next == bqc_pkg::CH_LSQUARE))
                       ? bqc_pkg::ST_OVERFLOW : bqc_pkg::ST_UNEXP_CLOSE;
        end
        else if (count_next != '0)
        begin
            res.status = bqc_pkg::ST_UNCLOSED;
            res.line   = top_next.line;
            res.ch     = top_next.square ? bqc_pkg::CH_LSQUARE : bqc_pkg::CH_LCURLY;
        end
    end

    // output register and skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_new)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rd_sum  = count_next - bqc_pkg::CNT_W'(2);
    assign rd_addr = rd_sum[bqc_pkg::ADDR_W-1:0];

    // stack ram: one write, one registered read of the entry below the top
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[count_reg[bqc_pkg::ADDR_W-1:0]] <= push_entry;
        end
        below_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        top_reg       <= top_next;
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            line_reg       <= bqc_pkg::LINE_FIRST;
            parity_reg     <= 1'b0;
            prev_bs_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_char_reg  <= '0;
            err_valid_reg  <= 1'b0;
            err_status_reg <= bqc_pkg::ST_OK;
            err_line_reg   <= '0;
            err_char_reg   <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (res_new)
        begin
            // text done, back to the start state
            count_reg      <= '0;
            line_reg       <= bqc_pkg::LINE_FIRST;
            parity_reg     <= 1'b0;
            prev_bs_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_char_reg  <= '0;
            err_valid_reg  <= 1'b0;
            err_status_reg <= bqc_pkg::ST_OK;
            err_line_reg   <= '0;
            err_char_reg   <= '0;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        else
        begin
            count_reg      <= count_next;
            line_reg       <= line_next;
            parity_reg     <= parity_next;
            prev_bs_reg    <= prev_bs_next;
            pend_valid_reg <= pend_valid_next;
            pend_char_reg  <= pend_char_next;
            err_valid_reg  <= err_valid_next;
            err_status_reg <= err_status_next;
            err_line_reg   <= err_line_next;
            err_char_reg   <= err_char_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    `BQC_ASSERT_NOW(a_depth, 1'b1, count_reg <= bqc_pkg::CNT_W'(bqc_pkg::STACK_DEPTH), "stack count beyond depth")
    `BQC_ASSERT_NOW(a_skid_order, skid_valid_reg, out_valid_reg, "skid held with empty output register")
    `BQC_ASSERT_NOW(a_err_code, err_valid_reg, err_status_reg != bqc_pkg::ST_OK, "latched error without a code")
    `BQC_ASSERT_NEXT(a_restart, res_new, (count_reg == '0) && !err_valid_reg && !pend_valid_reg, "state not cleared after last byte")
    `BQC_ASSERT_NEXT(a_result, res_new, out_valid_reg, "last byte gave no result")

endmodule

FILE: verif/bracket_quote_balance_checker_unit_tb.sv
// testbench for bracket_quote_balance_checker_unit: drives texts byte by byte, predicts
// each report and checks it field by field; needs bqc_pkg, bqc_text_if, bqc_report_if
module bracket_quote_balance_checker_unit_tb;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bqc_text_if   text_ch ();
    bqc_report_if report_ch ();

    bracket_quote_balance_checker_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .report (report_ch)
    );

    always #6 clk = ~clk;

    text_beat_t         text_beats[$];
    bqc_pkg::result_t   expected_reports[$];
    logic [7:0]         text_buf[$];

    int idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    int fail_count = 0;
    int beats_queued = 0;
    int beats_taken = 0;
    int reports_checked = 0;
    int texts_queued = 0;
    logic text_took = 1'b0;

    // predicted checker state
    bqc_pkg::entry_t               open_stack_m[bqc_pkg::STACK_DEPTH];
    int                            depth_m;
    logic [bqc_pkg::LINE_BITS-1:0] line_m;
    bit                            parity_m;
    bit                            prev_bs_m;
    bit                            pend_m;
    logic [7:0]                    pend_ch_m;
    bit                            err_held;
    bqc_pkg::status_t              err_status;
    logic [bqc_pkg::LINE_BITS-1:0] err_line;
    logic [7:0]                    err_ch;

    function automatic void clear_model();
        depth_m    = 0;
        line_m     = bqc_pkg::LINE_FIRST;
        parity_m   = 1'b0;
        prev_bs_m  = 1'b0;
        pend_m     = 1'b0;
        pend_ch_m  = 8'h00;
        err_held   = 1'b0;
        err_status = bqc_pkg::ST_OK;
        err_line   = '0;
        err_ch     = 8'h00;
    endfunction

    function automatic void latch_error(bqc_pkg::status_t st,
                                        logic [bqc_pkg::LINE_BITS-1:0] ln,
                                        logic [7:0] ch);
        if (!err_held)
        begin
            err_held   = 1'b1;
            err_status = st;
            err_line   = ln;
            err_ch     = ch;
        end
    endfunction

    function automatic void end_of_line();
        if (parity_m)
            latch_error(bqc_pkg::ST_ODD_QUOTE, line_m, bqc_pkg::CH_QUOTE);
        else if (pend_m)
        begin
            if (pend_ch_m == bqc_pkg::CH_LCURLY || pend_ch_m == bqc_pkg::CH_LSQUARE)
                latch_error(bqc_pkg::ST_OVERFLOW, line_m, pend_ch_m);
            else
                latch_error(bqc_pkg::ST_UNEXP_CLOSE, line_m, pend_ch_m);
        end
        parity_m  = 1'b0;
        pend_m    = 1'b0;
        pend_ch_m = 8'h00;
    endfunction

    function automatic void bracket_step(logic [7:0] c);
        bqc_pkg::entry_t top;
        bit              ok;
        if (c == bqc_pkg::CH_LCURLY || c == bqc_pkg::CH_LSQUARE)
        begin
            if (depth_m >= bqc_pkg::STACK_DEPTH)
            begin
                pend_m    = 1'b1;
                pend_ch_m = c;
            end
            else
            begin
                open_stack_m[depth_m].line   = line_m;
                open_stack_m[depth_m].square = (c == bqc_pkg::CH_LSQUARE);
                depth_m++;
            end
        end
        else if (c == bqc_pkg::CH_RCURLY || c == bqc_pkg::CH_RSQUARE)
        begin
            ok = 1'b0;
            if (depth_m > 0)
            begin
                top = open_stack_m[depth_m - 1];
                ok  = (c == bqc_pkg::CH_RSQUARE) ? top.square : !top.square;
            end
            if (ok)
                depth_m--;
            else
            begin
                pend_m    = 1'b1;
                pend_ch_m = c;
            end
        end
    endfunction

    function automatic bit check_byte(logic [7:0] c, logic last, output bqc_pkg::result_t r);
        bqc_pkg::entry_t top;
        r = '0;
        if (!err_held)
        begin
            if (c == bqc_pkg::CH_NL)
            begin
                end_of_line();
                if (line_m != bqc_pkg::LINE_MAX)
                    line_m++;
            end
            else
            begin
                if (c == bqc_pkg::CH_QUOTE && !prev_bs_m)
                    parity_m = ~parity_m;
                if (!pend_m)
                    bracket_step(c);
            end
        end
        prev_bs_m = (c == bqc_pkg::CH_BSLASH);
        if (!last)
            return 1'b0;
        if (!err_held)
            end_of_line();
        if (!err_held && depth_m > 0)
        begin
            top = open_stack_m[depth_m - 1];
            latch_error(bqc_pkg::ST_UNCLOSED, top.line,
                        top.square ? bqc_pkg::CH_LSQUARE : bqc_pkg::CH_LCURLY);
        end
        if (err_held)
        begin
            r.status = err_status;
            r.line   = err_line;
            r.ch     = err_ch;
        end
        else
        begin
            r.status = bqc_pkg::ST_OK;
            r.line   = '0;
            r.ch     = 8'h00;
        end
        clear_model();
        return 1'b1;
    endfunction

    // text building
    function automatic void put(logic [7:0] b);
        text_buf = {text_buf, b};
    endfunction

    function automatic void flush_text();
        text_beat_t tb;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            tb.ch   = text_buf[i];
            tb.last = (i == text_buf.size() - 1);
            text_beats = {text_beats, tb};
        end
        beats_queued += text_buf.size();
        texts_queued++;
        text_buf.delete();
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(32, 126));
        if (b == bqc_pkg::CH_LCURLY || b == bqc_pkg::CH_LSQUARE || b == bqc_pkg::CH_RCURLY ||
            b == bqc_pkg::CH_RSQUARE || b == bqc_pkg::CH_QUOTE || b == bqc_pkg::CH_BSLASH)
            b = 8'h61;
        return b;
    endfunction

    function automatic logic [7:0] special_byte();
        logic [7:0] b;
        case ($urandom_range(6))
            0:       b = bqc_pkg::CH_LCURLY;
            1:       b = bqc_pkg::CH_LSQUARE;
            2:       b = bqc_pkg::CH_RCURLY;
            3:       b = bqc_pkg::CH_RSQUARE;
            4:       b = bqc_pkg::CH_QUOTE;
            5:       b = bqc_pkg::CH_BSLASH;
            default: b = bqc_pkg::CH_NL;
        endcase
        return b;
    endfunction

    function automatic void build_nested();
        bit sq[16];
        int depth;
        int steps;
        int maxd;
        int k;
        depth = 0;
        steps = $urandom_range(3, 30);
        maxd  = $urandom_range(1, 8);
        for (int s = 0; s < steps; s++)
        begin
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    if (depth < maxd)
                    begin
                        sq[depth] = 1'($urandom_range(1));
                        put(sq[depth] ? bqc_pkg::CH_LSQUARE : bqc_pkg::CH_LCURLY);
                        depth++;
                    end
                    else
                        put(plain_byte());
                end
                3, 4:
                begin
                    if (depth > 0)
                    begin
                        depth--;
                        put(sq[depth] ? bqc_pkg::CH_RSQUARE : bqc_pkg::CH_RCURLY);
                    end
                end
                5:
                begin
                    put(bqc_pkg::CH_QUOTE);
                    k = $urandom_range(4);
                    for (int j = 0; j < k; j++)
                    begin
                        if ($urandom_range(4) == 0)
                        begin
                            put(bqc_pkg::CH_BSLASH);
                            put(bqc_pkg::CH_QUOTE);
                        end
                        else
                            put(plain_byte());
                    end
                    put(bqc_pkg::CH_QUOTE);
                end
                6: put(bqc_pkg::CH_NL);
                7:
                begin
                    put(bqc_pkg::CH_BSLASH);
                    put($urandom_range(1) ? special_byte() : plain_byte());
                end
                default: put(plain_byte());
            endcase
        end
        if ($urandom_range(3) != 0)
        begin
            while (depth > 0)
            begin
                depth--;
                if ($urandom_range(5) == 0)
                    put(bqc_pkg::CH_NL);
                put(sq[depth] ? bqc_pkg::CH_RSQUARE : bqc_pkg::CH_RCURLY);
            end
        end
        if (text_buf.size() == 0)
            put(plain_byte());
        if ($urandom_range(2) == 0)
        begin
            k = $urandom_range(text_buf.size() - 1);
            text_buf[k] = $urandom_range(1) ? special_byte() : 8'($urandom_range(255));
        end
    endfunction

    function automatic void build_noise();
        int n;
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
            put($urandom_range(1) ? special_byte() : 8'($urandom_range(255)));
    endfunction

    // long runs of openers to reach a full stack and beyond
    function automatic void build_deep(int n);
        bit sq[80];
        for (int i = 0; i < n; i++)
        begin
            sq[i] = 1'($urandom_range(1));
            put(sq[i] ? bqc_pkg::CH_LSQUARE : bqc_pkg::CH_LCURLY);
            if ($urandom_range(9) == 0)
                put(bqc_pkg::CH_NL);
        end
        if ($urandom_range(3) == 0)
            put(bqc_pkg::CH_QUOTE);
        for (int i = n - 1; i >= 0; i--)
            put(sq[i] ? bqc_pkg::CH_RSQUARE : bqc_pkg::CH_RCURLY);
    endfunction

    function automatic void queue_directed();
        put(8'h00); flush_text();
        put(8'hFF); flush_text();
        put(bqc_pkg::CH_LCURLY); put(bqc_pkg::CH_LSQUARE);
        put(bqc_pkg::CH_RSQUARE); put(bqc_pkg::CH_RCURLY); flush_text();
        put(bqc_pkg::CH_BSLASH); flush_text();
        // a quote opening a text has no byte before it
        put(bqc_pkg::CH_QUOTE); flush_text();
        put(bqc_pkg::CH_BSLASH); put(bqc_pkg::CH_QUOTE); flush_text();
        put(bqc_pkg::CH_RCURLY); flush_text();
        put(bqc_pkg::CH_LSQUARE); put(bqc_pkg::CH_RCURLY); flush_text();
        // odd quotes win over a closer on the same line
        put(bqc_pkg::CH_QUOTE); put(bqc_pkg::CH_RSQUARE); flush_text();
        put(bqc_pkg::CH_LCURLY); put(bqc_pkg::CH_NL); flush_text();
        // bytes after a latched error are ignored
        put(bqc_pkg::CH_RSQUARE); put(bqc_pkg::CH_NL);
        put(bqc_pkg::CH_QUOTE); put(8'h78); flush_text();
        put(bqc_pkg::CH_NL); put(bqc_pkg::CH_LSQUARE); put(bqc_pkg::CH_LCURLY); flush_text();
    endfunction

    task automatic wait_for_drain();
        while (beats_taken != beats_queued || expected_reports.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // driver
    always @(negedge clk)
    begin : text_driver
        text_beat_t tb;
        if (!rst_n)
        begin
            text_ch.valid     <= 1'b0;
            text_ch.char_code <= 8'h00;
            text_ch.last_char <= 1'b0;
            report_ch.ready   <= 1'b0;
        end
        else
        begin
            report_ch.ready <= ($urandom_range(99) >= stall_pct);
            if (!text_ch.valid || text_took)
            begin
                if (text_beats.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    tb = text_beats.pop_front();
                    text_ch.valid     <= 1'b1;
                    text_ch.char_code <= tb.ch;
                    text_ch.last_char <= tb.last;
                end
                else
                    text_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : report_monitor
        bqc_pkg::result_t exp_r;
        bqc_pkg::result_t next_r;
        if (!rst_n)
            text_took <= 1'b0;
        else
        begin
            cycle_count++;
            if (report_ch.valid && report_ch.ready)
            begin
                reports_checked++;
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: report with none expected: status %0d line %0d char %02h",
                             $time, report_ch.status, report_ch.error_line,
                             report_ch.error_char);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_reports.pop_front();
                    if (report_ch.status !== exp_r.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, report_ch.status);
                        fail_count++;
                    end
                    if (report_ch.error_line !== exp_r.line)
                    begin
                        $display("%0t: error_line expected %0d actual %0d",
                                 $time, exp_r.line, report_ch.error_line);
                        fail_count++;
                    end
                    if (report_ch.error_char !== exp_r.ch)
                    begin
                        $display("%0t: error_char expected %02h actual %02h",
                                 $time, exp_r.ch, report_ch.error_char);
                        fail_count++;
                    end
                end
            end
            if (text_ch.valid && text_ch.ready)
            begin
                beats_taken++;
                if (check_byte(text_ch.char_code, text_ch.last_char, next_r))
                    expected_reports = {expected_reports, next_r};
            end
            text_took <= text_ch.valid && text_ch.ready;
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int idle_set[4];
        int stall_set[4];
        int start_beats;
        int pick;
        idle_set  = '{0, 75, 0, 37};
        stall_set = '{0, 0, 75, 37};
        clear_model();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = idle_set[ph];
            stall_pct = stall_set[ph];
            if (ph == 0)
                queue_directed();
            start_beats = beats_queued;
            while (beats_queued - start_beats < 450)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                    build_nested();
                else if (pick < 96)
                    build_noise();
                else
                    build_deep($urandom_range(58, 70));
                flush_text();
            end
            wait_for_drain();
        end
        $display("covered %0d texts, %0d bytes and %0d reports under four handshake mixes",
                 texts_queued, beats_taken, reports_checked);
        $display("including short directed texts and full-stack overflow");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/bqc_pkg.sv
sv/bqc_text_if.sv
sv/bqc_report_if.sv
sv/bracket_quote_balance_checker_unit.sv
verif/bracket_quote_balance_checker_unit_tb.sv
